// ===== sv/text_terminal_buffer_engine_unit_assert.svh =====
// Assertion macros for the text terminal engine. Clocked on clk, reset rst.
`ifndef TEXT_TERMINAL_BUFFER_ENGINE_UNIT_ASSERT_SVH
`define TEXT_TERMINAL_BUFFER_ENGINE_UNIT_ASSERT_SVH

// check while out of reset
`define TTBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check at every edge, reset included
`define TTBE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/ttbe_pkg.sv =====
// ----------------------------------------------------------------------------
// ttbe_pkg
// Shared types and codes of the text terminal engine: opcodes, controller
// states, datapath commands and the datapath status bundle.
// ----------------------------------------------------------------------------
package ttbe_pkg;

  typedef enum logic [3:0] {
    OP_PUT         = 4'd0,
    OP_BACKSPACE   = 4'd1,
    OP_DELETE      = 4'd2,
    OP_LEFT        = 4'd3,
    OP_RIGHT       = 4'd4,
    OP_UP          = 4'd5,
    OP_DOWN        = 4'd6,
    OP_GOTO        = 4'd7,
    OP_CLEAR       = 4'd8,
    OP_CLRLINE     = 4'd9,
    OP_CLREOL      = 4'd10,
    OP_SCROLL_UP   = 4'd11,
    OP_SCROLL_DOWN = 4'd12,
    OP_INVERT      = 4'd13,
    OP_READ        = 4'd14,
    OP_ACK         = 4'd15
  } op_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  localparam logic REG_WORD_WRAP   = 1'b0;
  localparam logic REG_SCROLL_LOCK = 1'b1;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_FILL,
    S_COPY_RD,
    S_COPY_WR,
    S_PUT_MOVE,
    S_CR_MOVE,
    S_TAB_CHK,
    S_TAB_MOVE,
    S_TAB_TEST,
    S_DEL_CHK,
    S_DEL_TAIL,
    S_SC1,
    S_SCR_TAIL,
    S_READ_CAP,
    S_DONE
  } state_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LATCH,
    DP_FILL_STEP,
    DP_COPY_RD,
    DP_COPY_WR,
    DP_SET_INIT,
    DP_SET_CLEAR,
    DP_SET_HOME_SP,
    DP_SET_ROW_FILL,
    DP_SET_EOL_CH,
    DP_SET_EOL_SP,
    DP_SET_CELL_CH,
    DP_SET_CELL_SP,
    DP_SET_DEL_COPY,
    DP_SET_DEL_TAIL,
    DP_SET_SCROLL_ONE,
    DP_SET_SCROLL_N,
    DP_SET_SCROLL_TAIL,
    DP_MOVE_RIGHT,
    DP_MOVE_LEFT,
    DP_MOVE_LEFT_BS,
    DP_UP,
    DP_DOWN,
    DP_GOTO,
    DP_CR_MOVE,
    DP_TAB_MARK,
    DP_INVERT,
    DP_READ_ADDR,
    DP_READ_CAP,
    DP_ACK
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic ch_tab;
    logic ch_cr;
    logic ch_ctrl;
    logic put_block;
    logic mr_scroll;
    logic row_last;
    logic col_last;
    logic row_ok;
    logic cnt_zero;
    logic cnt_full;
    logic scroll_lock;
    logic sweep_last;
    logic unchanged;
    logic at_stop;
  } dp_status_t;

endpackage

// ===== sv/ttbe_ram.sv =====
// ----------------------------------------------------------------------------
// ttbe_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ttbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 168
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ttbe_ctrl.sv =====
// ----------------------------------------------------------------------------
// ttbe_ctrl
// Command sequencer: decodes the latched command and steps the datapath
// through its cursor updates and grid sweeps.
// ----------------------------------------------------------------------------
module ttbe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  ttbe_pkg::dp_status_t st,
  output ttbe_pkg::dp_cmd_t   cmd,
  output logic                busy,
  output logic                done
);

  ttbe_pkg::state_t state, state_next;
  ttbe_pkg::state_t ret, ret_next;
  ttbe_pkg::state_t ret_scroll, ret_scroll_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ttbe_pkg::S_INIT;
      ret        <= ttbe_pkg::S_IDLE;
      ret_scroll <= ttbe_pkg::S_IDLE;
    end else begin
      state      <= state_next;
      ret        <= ret_next;
      ret_scroll <= ret_scroll_next;
    end
  end

  always_comb begin
    state_next      = state;
    ret_next        = ret;
    ret_scroll_next = ret_scroll;
    cmd             = ttbe_pkg::DP_NOP;
    busy            = 1'b1;
    done            = 1'b0;
    unique case (state)
      ttbe_pkg::S_INIT: begin
        cmd        = ttbe_pkg::DP_SET_INIT;
        ret_next   = ttbe_pkg::S_IDLE;
        state_next = ttbe_pkg::S_FILL;
      end
      ttbe_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd        = ttbe_pkg::DP_LATCH;
          state_next = ttbe_pkg::S_DECODE;
        end
      end
      ttbe_pkg::S_DECODE: begin
        state_next = ttbe_pkg::S_DONE;
        unique case (st.op) inside
          ttbe_pkg::OP_PUT: begin
            if (st.ch_tab) begin
              cmd        = ttbe_pkg::DP_TAB_MARK;
              state_next = ttbe_pkg::S_TAB_CHK;
            end else if (st.ch_cr) begin
              cmd        = ttbe_pkg::DP_SET_EOL_SP;
              ret_next   = ttbe_pkg::S_CR_MOVE;
              state_next = ttbe_pkg::S_FILL;
            end else if (!st.ch_ctrl && !st.put_block) begin
              cmd        = ttbe_pkg::DP_SET_CELL_CH;
              ret_next   = ttbe_pkg::S_PUT_MOVE;
              state_next = ttbe_pkg::S_FILL;
            end
          end
          ttbe_pkg::OP_BACKSPACE: begin
            cmd        = ttbe_pkg::DP_MOVE_LEFT_BS;
            state_next = ttbe_pkg::S_DEL_CHK;
          end
          ttbe_pkg::OP_DELETE: state_next = ttbe_pkg::S_DEL_CHK;
          ttbe_pkg::OP_LEFT:   cmd = ttbe_pkg::DP_MOVE_LEFT;
          ttbe_pkg::OP_RIGHT:  state_next = ttbe_pkg::S_PUT_MOVE;
          ttbe_pkg::OP_UP:     cmd = ttbe_pkg::DP_UP;
          ttbe_pkg::OP_DOWN:   cmd = ttbe_pkg::DP_DOWN;
          ttbe_pkg::OP_GOTO:   cmd = ttbe_pkg::DP_GOTO;
          ttbe_pkg::OP_CLEAR: begin
            cmd        = ttbe_pkg::DP_SET_CLEAR;
            ret_next   = ttbe_pkg::S_DONE;
            state_next = ttbe_pkg::S_FILL;
          end
          ttbe_pkg::OP_CLRLINE: begin
            if (st.row_ok) begin
              cmd        = ttbe_pkg::DP_SET_ROW_FILL;
              ret_next   = ttbe_pkg::S_DONE;
              state_next = ttbe_pkg::S_FILL;
            end
          end
          ttbe_pkg::OP_CLREOL: begin
            cmd        = ttbe_pkg::DP_SET_EOL_CH;
            ret_next   = ttbe_pkg::S_DONE;
            state_next = ttbe_pkg::S_FILL;
          end
          ttbe_pkg::OP_SCROLL_UP, ttbe_pkg::OP_SCROLL_DOWN: begin
            if (st.scroll_lock || st.cnt_zero) begin
              state_next = ttbe_pkg::S_DONE;
            end else if (st.cnt_full) begin
              cmd        = ttbe_pkg::DP_SET_HOME_SP;
              ret_next   = ttbe_pkg::S_DONE;
              state_next = ttbe_pkg::S_FILL;
            end else begin
              cmd             = ttbe_pkg::DP_SET_SCROLL_N;
              ret_next        = ttbe_pkg::S_SCR_TAIL;
              ret_scroll_next = ttbe_pkg::S_DONE;
              state_next      = ttbe_pkg::S_COPY_RD;
            end
          end
          ttbe_pkg::OP_INVERT: begin
            if (st.row_ok) begin
              cmd = ttbe_pkg::DP_INVERT;
            end
          end
          ttbe_pkg::OP_READ: begin
            cmd        = ttbe_pkg::DP_READ_ADDR;
            state_next = ttbe_pkg::S_READ_CAP;
          end
          ttbe_pkg::OP_ACK: cmd = ttbe_pkg::DP_ACK;
          default: state_next = ttbe_pkg::S_DONE;
        endcase
      end
      ttbe_pkg::S_FILL: begin
        cmd = ttbe_pkg::DP_FILL_STEP;
        if (st.sweep_last) begin
          state_next = ret;
        end
      end
      ttbe_pkg::S_COPY_RD: begin
        cmd        = ttbe_pkg::DP_COPY_RD;
        state_next = ttbe_pkg::S_COPY_WR;
      end
      ttbe_pkg::S_COPY_WR: begin
        cmd        = ttbe_pkg::DP_COPY_WR;
        state_next = st.sweep_last ? ret : ttbe_pkg::S_COPY_RD;
      end
      ttbe_pkg::S_PUT_MOVE: begin
        cmd = ttbe_pkg::DP_MOVE_RIGHT;
        if (st.mr_scroll) begin
          ret_scroll_next = ttbe_pkg::S_DONE;
          state_next      = ttbe_pkg::S_SC1;
        end else begin
          state_next = ttbe_pkg::S_DONE;
        end
      end
      ttbe_pkg::S_CR_MOVE: begin
        cmd = ttbe_pkg::DP_CR_MOVE;
        if (st.row_last) begin
          ret_scroll_next = ttbe_pkg::S_DONE;
          state_next      = ttbe_pkg::S_SC1;
        end else begin
          state_next = ttbe_pkg::S_DONE;
        end
      end
      ttbe_pkg::S_TAB_CHK: begin
        if (st.put_block) begin
          state_next = ttbe_pkg::S_DONE;
        end else begin
          cmd        = ttbe_pkg::DP_SET_CELL_SP;
          ret_next   = ttbe_pkg::S_TAB_MOVE;
          state_next = ttbe_pkg::S_FILL;
        end
      end
      ttbe_pkg::S_TAB_MOVE: begin
        cmd = ttbe_pkg::DP_MOVE_RIGHT;
        if (st.mr_scroll) begin
          ret_scroll_next = ttbe_pkg::S_TAB_TEST;
          state_next      = ttbe_pkg::S_SC1;
        end else begin
          state_next = ttbe_pkg::S_TAB_TEST;
        end
      end
      ttbe_pkg::S_TAB_TEST: begin
        // stop on a tab stop or when the cursor is stuck
        if (st.unchanged || st.at_stop) begin
          state_next = ttbe_pkg::S_DONE;
        end else begin
          state_next = ttbe_pkg::S_TAB_CHK;
        end
      end
      ttbe_pkg::S_DEL_CHK: begin
        if (st.col_last) begin
          state_next = ttbe_pkg::S_DONE;
        end else begin
          cmd        = ttbe_pkg::DP_SET_DEL_COPY;
          ret_next   = ttbe_pkg::S_DEL_TAIL;
          state_next = ttbe_pkg::S_COPY_RD;
        end
      end
      ttbe_pkg::S_DEL_TAIL: begin
        cmd        = ttbe_pkg::DP_SET_DEL_TAIL;
        ret_next   = ttbe_pkg::S_DONE;
        state_next = ttbe_pkg::S_FILL;
      end
      ttbe_pkg::S_SC1: begin
        if (st.scroll_lock) begin
          state_next = ret_scroll;
        end else begin
          cmd        = ttbe_pkg::DP_SET_SCROLL_ONE;
          ret_next   = ttbe_pkg::S_SCR_TAIL;
          state_next = ttbe_pkg::S_COPY_RD;
        end
      end
      ttbe_pkg::S_SCR_TAIL: begin
        cmd        = ttbe_pkg::DP_SET_SCROLL_TAIL;
        ret_next   = ret_scroll;
        state_next = ttbe_pkg::S_FILL;
      end
      ttbe_pkg::S_READ_CAP: begin
        cmd        = ttbe_pkg::DP_READ_CAP;
        state_next = ttbe_pkg::S_DONE;
      end
      ttbe_pkg::S_DONE: begin
        done       = 1'b1;
        state_next = ttbe_pkg::S_IDLE;
      end
      default: state_next = ttbe_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== sv/ttbe_datapath.sv =====
// ----------------------------------------------------------------------------
// ttbe_datapath
// Cursor, row flags, mode registers, latched command fields and the sweep
// engine that fills and moves cells in the character grid RAM.
// ----------------------------------------------------------------------------
module ttbe_datapath #(
  parameter int COLUMNS  = 21,
  parameter int ROWS     = 8,
  parameter int TAB_STOP = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ttbe_pkg::dp_cmd_t    cmd,
  output ttbe_pkg::dp_status_t st,
  input  logic [3:0]           opcode,
  input  logic [7:0]           char_code,
  input  logic [4:0]           column,
  input  logic [2:0]           row,
  input  logic [3:0]           count,
  input  logic                 flag,
  input  logic                 wr_en,
  input  logic                 wr_index,
  input  logic                 wr_data,
  output logic [4:0]           cursor_col,
  output logic [2:0]           cursor_line,
  output logic [7:0]           read_char,
  output logic                 read_inverse,
  output logic [7:0]           dirty_rows
);

  localparam int CW    = $clog2(COLUMNS);
  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [2:0]    ROW_LAST  = 3'(ROWS - 1);
  localparam logic [AW-1:0] ADDR_COLS = AW'(COLUMNS);
  localparam logic [AW-1:0] ADDR_LAST = AW'(CELLS - 1);
  localparam logic [AW-1:0] ADDR_ONE  = AW'(1);

  // tab stop table, one bit per column
  logic [COLUMNS-1:0] stop_vec;
  for (genvar g = 0; g < COLUMNS; g++) begin : g_stop
    localparam bit IS_STOP = (g % TAB_STOP) == 0;
    assign stop_vec[g] = IS_STOP;
  end

  logic [CW-1:0] cur_col, pc;
  logic [2:0]    cur_row, pr;
  logic [7:0]    row_inverse, row_dirty;
  logic          word_wrap, scroll_lock;

  ttbe_pkg::op_t l_op;
  logic [7:0]    l_ch;
  logic [4:0]    l_col;
  logic [2:0]    l_row;
  logic [3:0]    l_cnt;
  logic          l_flg;

  logic [AW-1:0] sw_addr, sw_last, sw_off;
  logic          sw_down;
  logic [7:0]    sw_ch;

  logic [7:0]    rd_char;
  logic          rd_inv;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic [CW-1:0] goto_col;
  logic [2:0]    goto_row;
  logic [AW-1:0] cur_cell, row_end, lrow_base, scr_off, goto_cell, copy_src;

  assign goto_col  = (int'(l_col) >= COLUMNS) ? COL_LAST : CW'(l_col);
  assign goto_row  = (int'(l_row) >= ROWS) ? ROW_LAST : l_row;
  assign cur_cell  = AW'(cur_row) * ADDR_COLS + AW'(cur_col);
  assign row_end   = AW'(cur_row) * ADDR_COLS + ADDR_COLS - ADDR_ONE;
  assign lrow_base = AW'(l_row) * ADDR_COLS;
  assign scr_off   = AW'(l_cnt[2:0]) * ADDR_COLS;
  assign goto_cell = AW'(goto_row) * ADDR_COLS + AW'(goto_col);
  assign copy_src  = sw_down ? (sw_addr - sw_off) : (sw_addr + sw_off);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sw_addr;
    ram_wdata = sw_ch;
    ram_raddr = copy_src;
    case (cmd)
      ttbe_pkg::DP_FILL_STEP: ram_we = 1'b1;
      ttbe_pkg::DP_COPY_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      ttbe_pkg::DP_READ_ADDR: ram_raddr = goto_cell;
      default: ram_we = 1'b0;
    endcase
  end

  ttbe_ram #(.WIDTH(8), .DEPTH(CELLS)) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // command fields, sweep registers
  always_ff @(posedge clk) begin
    unique case (cmd)
      ttbe_pkg::DP_LATCH: begin
        l_op  <= ttbe_pkg::op_t'(opcode);
        l_ch  <= char_code;
        l_col <= column;
        l_row <= row;
        l_cnt <= count;
        l_flg <= flag;
      end
      ttbe_pkg::DP_FILL_STEP: sw_addr <= sw_addr + ADDR_ONE;
      ttbe_pkg::DP_COPY_WR:   sw_addr <= sw_down ? sw_addr - ADDR_ONE : sw_addr + ADDR_ONE;
      ttbe_pkg::DP_SET_INIT, ttbe_pkg::DP_SET_HOME_SP, ttbe_pkg::DP_SET_CLEAR: begin
        sw_addr <= '0;
        sw_last <= ADDR_LAST;
        sw_ch   <= (cmd == ttbe_pkg::DP_SET_CLEAR) ? l_ch : ttbe_pkg::CH_SPACE;
      end
      ttbe_pkg::DP_SET_ROW_FILL: begin
        sw_addr <= lrow_base;
        sw_last <= lrow_base + ADDR_COLS - ADDR_ONE;
        sw_ch   <= l_ch;
      end
      ttbe_pkg::DP_SET_EOL_CH, ttbe_pkg::DP_SET_EOL_SP: begin
        sw_addr <= cur_cell;
        sw_last <= row_end;
        sw_ch   <= (cmd == ttbe_pkg::DP_SET_EOL_CH) ? l_ch : ttbe_pkg::CH_SPACE;
      end
      ttbe_pkg::DP_SET_CELL_CH, ttbe_pkg::DP_SET_CELL_SP: begin
        sw_addr <= cur_cell;
        sw_last <= cur_cell;
        sw_ch   <= (cmd == ttbe_pkg::DP_SET_CELL_CH) ? l_ch : ttbe_pkg::CH_SPACE;
        pc      <= cur_col;
        pr      <= cur_row;
      end
      ttbe_pkg::DP_SET_DEL_COPY: begin
        sw_addr <= cur_cell;
        sw_last <= row_end - ADDR_ONE;
        sw_off  <= ADDR_ONE;
        sw_down <= 1'b0;
      end
      ttbe_pkg::DP_SET_DEL_TAIL: begin
        sw_addr <= row_end;
        sw_last <= row_end;
        sw_ch   <= ttbe_pkg::CH_SPACE;
      end
      ttbe_pkg::DP_SET_SCROLL_ONE: begin
        sw_addr <= '0;
        sw_last <= ADDR_LAST - ADDR_COLS;
        sw_off  <= ADDR_COLS;
        sw_down <= 1'b0;
      end
      ttbe_pkg::DP_SET_SCROLL_N: begin
        sw_off <= scr_off;
        if (l_op == ttbe_pkg::OP_SCROLL_DOWN) begin
          sw_down <= 1'b1;
          sw_addr <= ADDR_LAST;
          sw_last <= scr_off;
        end else begin
          sw_down <= 1'b0;
          sw_addr <= '0;
          sw_last <= ADDR_LAST - scr_off;
        end
      end
      ttbe_pkg::DP_SET_SCROLL_TAIL: begin
        sw_ch <= ttbe_pkg::CH_SPACE;
        if (sw_down) begin
          sw_addr <= '0;
          sw_last <= sw_off - ADDR_ONE;
        end else begin
          sw_addr <= ADDR_LAST - sw_off + ADDR_ONE;
          sw_last <= ADDR_LAST;
        end
      end
      default: sw_ch <= sw_ch;
    endcase
  end

  // cursor, flags, modes
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col     <= '0;
      cur_row     <= '0;
      row_inverse <= '0;
      row_dirty   <= '0;
      word_wrap   <= 1'b1;
      scroll_lock <= 1'b0;
      rd_char     <= '0;
      rd_inv      <= 1'b0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          ttbe_pkg::REG_WORD_WRAP:   word_wrap   <= wr_data;
          ttbe_pkg::REG_SCROLL_LOCK: scroll_lock <= wr_data;
          default:                   word_wrap   <= word_wrap;
        endcase
      end
      unique case (cmd)
        ttbe_pkg::DP_LATCH: begin
          rd_char <= '0;
          rd_inv  <= 1'b0;
        end
        ttbe_pkg::DP_SET_CLEAR, ttbe_pkg::DP_SET_HOME_SP: begin
          cur_col   <= '0;
          cur_row   <= '0;
          row_dirty <= '1;
          if (cmd == ttbe_pkg::DP_SET_CLEAR && l_flg) begin
            row_inverse <= '0;
          end
        end
        ttbe_pkg::DP_SET_SCROLL_ONE, ttbe_pkg::DP_SET_SCROLL_N: row_dirty <= '1;
        ttbe_pkg::DP_SET_ROW_FILL: row_dirty[l_row] <= 1'b1;
        ttbe_pkg::DP_SET_EOL_CH, ttbe_pkg::DP_SET_EOL_SP, ttbe_pkg::DP_SET_CELL_CH,
        ttbe_pkg::DP_SET_CELL_SP, ttbe_pkg::DP_SET_DEL_COPY, ttbe_pkg::DP_TAB_MARK:
          row_dirty[cur_row] <= 1'b1;
        ttbe_pkg::DP_MOVE_RIGHT: begin
          if (cur_col != COL_LAST) begin
            cur_col <= cur_col + CW'(1);
          end else if (word_wrap && !(scroll_lock && cur_row == ROW_LAST)) begin
            // wrap; the bottom row stays put and the grid scrolls instead
            row_dirty[cur_row] <= 1'b1;
            cur_col            <= '0;
            if (cur_row != ROW_LAST) begin
              cur_row <= cur_row + 3'd1;
            end
          end
        end
        ttbe_pkg::DP_MOVE_LEFT, ttbe_pkg::DP_MOVE_LEFT_BS: begin
          if (cmd == ttbe_pkg::DP_MOVE_LEFT_BS) begin
            row_dirty[cur_row] <= 1'b1;
          end
          if (cur_col != '0) begin
            cur_col <= cur_col - CW'(1);
          end else if (cur_row != '0 && word_wrap) begin
            row_dirty[cur_row] <= 1'b1;
            cur_row            <= cur_row - 3'd1;
            cur_col            <= COL_LAST;
          end
        end
        ttbe_pkg::DP_UP: begin
          row_dirty[cur_row] <= 1'b1;
          if (cur_row != '0) begin
            cur_row <= cur_row - 3'd1;
          end
        end
        ttbe_pkg::DP_DOWN: begin
          if (cur_row != ROW_LAST) begin
            row_dirty[cur_row] <= 1'b1;
            cur_row            <= cur_row + 3'd1;
          end
        end
        ttbe_pkg::DP_GOTO: begin
          if (goto_row != cur_row) begin
            row_dirty[cur_row] <= 1'b1;
          end
          cur_col <= goto_col;
          cur_row <= goto_row;
        end
        ttbe_pkg::DP_CR_MOVE: begin
          cur_col <= '0;
          if (cur_row != ROW_LAST) begin
            cur_row <= cur_row + 3'd1;
          end
        end
        ttbe_pkg::DP_INVERT: begin
          row_inverse[l_row] <= l_flg;
          row_dirty[l_row]   <= 1'b1;
        end
        ttbe_pkg::DP_READ_CAP: begin
          rd_char <= ram_rdata;
          rd_inv  <= row_inverse[goto_row];
        end
        ttbe_pkg::DP_ACK: row_dirty <= '0;
        default: rd_inv <= rd_inv;
      endcase
    end
  end

  always_comb begin
    st.op          = l_op;
    st.ch_tab      = (l_ch == ttbe_pkg::CH_TAB);
    st.ch_cr       = (l_ch == ttbe_pkg::CH_CR);
    st.ch_ctrl     = (l_ch < ttbe_pkg::CH_SPACE);
    st.put_block   = !word_wrap && (cur_col == COL_LAST);
    st.mr_scroll   = (cur_col == COL_LAST) && word_wrap && !scroll_lock &&
                     (cur_row == ROW_LAST);
    st.row_last    = (cur_row == ROW_LAST);
    st.col_last    = (cur_col == COL_LAST);
    st.row_ok      = int'(l_row) < ROWS;
    st.cnt_zero    = (l_cnt == '0);
    st.cnt_full    = int'(l_cnt) >= ROWS;
    st.scroll_lock = scroll_lock;
    st.sweep_last  = (sw_addr == sw_last);
    st.unchanged   = (pc == cur_col) && (pr == cur_row);
    st.at_stop     = stop_vec[cur_col];
  end

  assign cursor_col   = 5'(cur_col);
  assign cursor_line  = cur_row;
  assign read_char    = rd_char;
  assign read_inverse = rd_inv;
  assign dirty_rows   = row_dirty;

endmodule

// ===== sv/text_terminal_buffer_engine_unit.sv =====
// ----------------------------------------------------------------------------
// text_terminal_buffer_engine_unit
// Text-mode terminal engine: character grid, cursor, per-row inverse and
// dirty flags, with word wrap and scroll lock modes.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to issue one command; each command returns
// exactly one result, shown for a single cycle with done high, and the next
// command can be issued in the cycle after done. The grid sits in a RAM that
// moves one cell per cycle for fills, while copies read and then write each
// cell, so timing follows the cells touched; a tab repeats the put per
// column it covers. After reset the engine blanks the grid with busy high;
// configuration writes are taken during that time.
// ----------------------------------------------------------------------------
`include "text_terminal_buffer_engine_unit_assert.svh"

module text_terminal_buffer_engine_unit #(
  parameter int COLUMNS  = 21,
  parameter int ROWS     = 8,
  parameter int TAB_STOP = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  output logic       done,
  input  logic [3:0] opcode,
  input  logic [7:0] char_code,
  input  logic [4:0] column,
  input  logic [2:0] row,
  input  logic [3:0] count,
  input  logic       flag,
  output logic [4:0] cursor_col,
  output logic [2:0] cursor_line,
  output logic [7:0] read_char,
  output logic       read_inverse,
  output logic [7:0] dirty_rows,
  input  logic       wr_en,
  input  logic       wr_index,
  input  logic       wr_data
);

  ttbe_pkg::dp_cmd_t    cmd;
  ttbe_pkg::dp_status_t st;

  ttbe_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  ttbe_datapath #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .opcode       (opcode),
    .char_code    (char_code),
    .column       (column),
    .row          (row),
    .count        (count),
    .flag         (flag),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .cursor_col   (cursor_col),
    .cursor_line  (cursor_line),
    .read_char    (read_char),
    .read_inverse (read_inverse),
    .dirty_rows   (dirty_rows)
  );

  `TTBE_ASSERT_ALWAYS(a_reset_init, rst |=> busy, "no grid blanking pass after reset")
  `TTBE_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted transaction not busy")
  `TTBE_ASSERT(a_done_pulse, done |=> !done, "result strobe longer than one cycle")
  `TTBE_ASSERT(a_done_busy, done |-> busy, "result strobe outside a transaction")
  `TTBE_ASSERT(a_row_range, int'(cursor_line) < ROWS, "cursor row beyond last row")

endmodule
